// ===== rtl/core/psd_pkg.sv =====
// Shared widths, types and codes for the point-to-segment squared distance block.
package psd_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = 2 * COORD_BITS + 3;
  localparam int DIST_BITS  = 2 * COORD_BITS + 2;
  localparam int HALF_BITS  = DIST_BITS / 2;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [DIFF_BITS-1:0]   diff_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [DIST_BITS-1:0]   dist_t;
  typedef logic        [HALF_BITS-1:0]   half_t;
  typedef logic        [2*HALF_BITS-1:0] hprod_t;
  typedef logic        [2*DIST_BITS-1:0] wide_t;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_MID   = 2'd2
  } region_t;

  // Candidate distance and region; for an interior item sq_dist holds A.A.
  typedef struct packed {
    dist_t   sq_dist;
    region_t region;
  } side_t;

endpackage

// ===== rtl/core/psd_if.sv =====
// Valid/ready channel interfaces for query items and distance results.
interface psd_in_if;
  logic               valid;
  logic               ready;
  psd_pkg::coord_t    start_x;
  psd_pkg::coord_t    start_y;
  psd_pkg::coord_t    start_z;
  psd_pkg::coord_t    end_x;
  psd_pkg::coord_t    end_y;
  psd_pkg::coord_t    end_z;
  psd_pkg::coord_t    query_x;
  psd_pkg::coord_t    query_y;
  psd_pkg::coord_t    query_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  query_x, query_y, query_z, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  query_x, query_y, query_z, output ready);
endinterface

interface psd_out_if;
  logic            valid;
  logic            ready;
  psd_pkg::dist_t  square_distance;
  logic [1:0]      region;

  modport source (output valid, square_distance, region, input ready);
  modport sink   (input valid, square_distance, region, output ready);
endinterface

// ===== rtl/core/point_segment_square_distance.sv =====
// Top level: streaming squared distance from a 3D point to a 3D segment.
//
// Each input transaction carries a segment (start, end) and a query point in
// signed fixed point; each yields exactly one output transaction with the
// squared distance (twice the coordinate fraction bits) and a region code:
// start when the projection P = (q-s).(e-s) is at or below zero (this covers a
// zero-length segment), end when P reaches L = |e-s|^2, otherwise interior,
// where the result is |q-s|^2 - floor(P*P / L). The block takes one
// transaction per cycle unless the output stalls and returns results in order
// through three front stages (differences, products, sums), two stages that
// square P, one restoring divider stage per quotient bit, and the output
// register. The whole pipe advances together whenever the output register is
// empty or being taken, so a stall on the output holds every stage and
// in_ch.ready drops with it.
// in_ch.ready is also held low while rst_n is asserted.
module point_segment_square_distance (
  input  logic       clk,
  input  logic       rst_n,
  psd_in_if.sink     in_ch,
  psd_out_if.source  out_ch
);

  logic            en;
  logic            f_vld, s_vld, d_vld;
  psd_pkg::dist_t  f_proj, f_len2, s_rem, s_low, s_len2, d_quot;
  psd_pkg::side_t  f_side, s_side, d_side;
  psd_pkg::dist_t  dist_nxt;
  psd_pkg::dist_t  dist_r;
  psd_pkg::region_t region_r;
  logic            out_vld_r;

  // Advance all stages when the output slot is free or being drained.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .s_x       (in_ch.start_x),
    .s_y       (in_ch.start_y),
    .s_z       (in_ch.start_z),
    .e_x       (in_ch.end_x),
    .e_y       (in_ch.end_y),
    .e_z       (in_ch.end_z),
    .q_x       (in_ch.query_x),
    .q_y       (in_ch.query_y),
    .q_z       (in_ch.query_z),
    .out_valid (f_vld),
    .proj      (f_proj),
    .len2      (f_len2),
    .side      (f_side)
  );

  psd_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_vld),
    .proj      (f_proj),
    .len2      (f_len2),
    .side_in   (f_side),
    .out_valid (s_vld),
    .rem       (s_rem),
    .low       (s_low),
    .len2_out  (s_len2),
    .side_out  (s_side)
  );

  // Outside the interior case the divider runs on don't-care data; its
  // quotient is dropped below.
  psd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_vld),
    .rem       (s_rem),
    .low       (s_low),
    .len2      (s_len2),
    .side_in   (s_side),
    .out_valid (d_vld),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  // Interior: subtract the quotient from |q-s|^2; it never goes negative.
  assign dist_nxt = (d_side.region == psd_pkg::REG_MID) ? d_side.sq_dist - d_quot
                                                       : d_side.sq_dist;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r   <= dist_nxt;
      region_r <= d_side.region;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d_vld;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.square_distance = dist_r;
  assign out_ch.region          = region_r;

endmodule

// ===== rtl/core/psd_front.sv =====
// Front pipeline: differences, products, dot-product sums and region decision.
module psd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  psd_pkg::coord_t  s_x, s_y, s_z,
  input  psd_pkg::coord_t  e_x, e_y, e_z,
  input  psd_pkg::coord_t  q_x, q_y, q_z,
  output logic             out_valid,
  output psd_pkg::dist_t   proj,
  output psd_pkg::dist_t   len2,
  output psd_pkg::side_t   side
);

  psd_pkg::diff_t dir_r [3];
  psd_pkg::diff_t a_r   [3];
  psd_pkg::diff_t b_r   [3];
  logic           v1_r, v2_r, v3_r;

  psd_pkg::prod_t pd_r [3];
  psd_pkg::prod_t ll_r [3];
  psd_pkg::prod_t ea_r [3];
  psd_pkg::prod_t eb_r [3];

  psd_pkg::sum_t  p_s, l_s, ea_s, eb_s;
  psd_pkg::dist_t proj_r, len2_r;
  psd_pkg::side_t side_r, side_nxt;

  // Stage 1: differences
  always_ff @(posedge clk) begin
    if (en) begin
      dir_r[0] <= psd_pkg::diff_t'(e_x) - psd_pkg::diff_t'(s_x);
      dir_r[1] <= psd_pkg::diff_t'(e_y) - psd_pkg::diff_t'(s_y);
      dir_r[2] <= psd_pkg::diff_t'(e_z) - psd_pkg::diff_t'(s_z);
      a_r[0]   <= psd_pkg::diff_t'(q_x) - psd_pkg::diff_t'(s_x);
      a_r[1]   <= psd_pkg::diff_t'(q_y) - psd_pkg::diff_t'(s_y);
      a_r[2]   <= psd_pkg::diff_t'(q_z) - psd_pkg::diff_t'(s_z);
      b_r[0]   <= psd_pkg::diff_t'(q_x) - psd_pkg::diff_t'(e_x);
      b_r[1]   <= psd_pkg::diff_t'(q_y) - psd_pkg::diff_t'(e_y);
      b_r[2]   <= psd_pkg::diff_t'(q_z) - psd_pkg::diff_t'(e_z);
    end
  end

  // Stage 2: per-axis products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pd_r[k] <= dir_r[k] * a_r[k];
        ll_r[k] <= dir_r[k] * dir_r[k];
        ea_r[k] <= a_r[k] * a_r[k];
        eb_r[k] <= b_r[k] * b_r[k];
      end
    end
  end

  // Stage 3: sums and region
  always_comb begin
    p_s  = psd_pkg::sum_t'(pd_r[0]) + psd_pkg::sum_t'(pd_r[1]) + psd_pkg::sum_t'(pd_r[2]);
    l_s  = psd_pkg::sum_t'(ll_r[0]) + psd_pkg::sum_t'(ll_r[1]) + psd_pkg::sum_t'(ll_r[2]);
    ea_s = psd_pkg::sum_t'(ea_r[0]) + psd_pkg::sum_t'(ea_r[1]) + psd_pkg::sum_t'(ea_r[2]);
    eb_s = psd_pkg::sum_t'(eb_r[0]) + psd_pkg::sum_t'(eb_r[1]) + psd_pkg::sum_t'(eb_r[2]);
    if (p_s <= 0) begin
      side_nxt.sq_dist = psd_pkg::dist_t'(ea_s);
      side_nxt.region  = psd_pkg::REG_START;
    end else if (p_s >= l_s) begin
      side_nxt.sq_dist = psd_pkg::dist_t'(eb_s);
      side_nxt.region  = psd_pkg::REG_END;
    end else begin
      side_nxt.sq_dist = psd_pkg::dist_t'(ea_s);
      side_nxt.region  = psd_pkg::REG_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj_r <= psd_pkg::dist_t'(p_s);
      len2_r <= psd_pkg::dist_t'(l_s);
      side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign proj      = proj_r;
  assign len2      = len2_r;
  assign side      = side_r;

endmodule

// ===== rtl/core/psd_square.sv =====
// Two-stage square of the projection, split into half-width partial products.
module psd_square (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  psd_pkg::dist_t  proj,
  input  psd_pkg::dist_t  len2,
  input  psd_pkg::side_t  side_in,
  output logic            out_valid,
  output psd_pkg::dist_t  rem,
  output psd_pkg::dist_t  low,
  output psd_pkg::dist_t  len2_out,
  output psd_pkg::side_t  side_out
);

  psd_pkg::half_t  ph, pl;
  psd_pkg::hprod_t hh_r, hl_r, ll_r;
  psd_pkg::dist_t  l1_r, l2_r;
  psd_pkg::side_t  s1_r, s2_r;
  psd_pkg::wide_t  pp_r;
  logic            v1_r, v2_r;

  assign ph = proj[psd_pkg::DIST_BITS-1:psd_pkg::HALF_BITS];
  assign pl = proj[psd_pkg::HALF_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ph * ph;
      hl_r <= ph * pl;
      ll_r <= pl * pl;
      l1_r <= len2;
      s1_r <= side_in;
      // P*P = hh<<2H + 2*hl<<H + ll
      pp_r <= {hh_r, ll_r} + (psd_pkg::wide_t'(hl_r) << (psd_pkg::HALF_BITS + 1));
      l2_r <= l1_r;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign rem       = pp_r[2*psd_pkg::DIST_BITS-1:psd_pkg::DIST_BITS];
  assign low       = pp_r[psd_pkg::DIST_BITS-1:0];
  assign len2_out  = l2_r;
  assign side_out  = s2_r;

endmodule

// ===== rtl/core/psd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module psd_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  psd_pkg::dist_t  rem,
  input  psd_pkg::dist_t  low,
  input  psd_pkg::dist_t  len2,
  input  psd_pkg::side_t  side_in,
  output logic            out_valid,
  output psd_pkg::dist_t  quot,
  output psd_pkg::side_t  side_out
);

  localparam int Q = psd_pkg::DIST_BITS;

  psd_pkg::dist_t rem_r  [Q];
  psd_pkg::dist_t lq_r   [Q];
  psd_pkg::dist_t len_r  [Q];
  psd_pkg::side_t side_r [Q];
  logic           vld_r  [Q];

  for (genvar i = 0; i < Q; i++) begin : g_stage
    psd_pkg::dist_t rem_src, lq_src, len_src;
    psd_pkg::side_t side_src;
    logic           vld_src;
    logic [Q:0]     trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_src  = rem;
      assign lq_src   = low;
      assign len_src  = len2;
      assign side_src = side_in;
      assign vld_src  = in_valid;
    end else begin : g_next
      assign rem_src  = rem_r[i-1];
      assign lq_src   = lq_r[i-1];
      assign len_src  = len_r[i-1];
      assign side_src = side_r[i-1];
      assign vld_src  = vld_r[i-1];
    end

    // Shift in the next dividend bit; quotient bits enter at the bottom.
    assign trial = {rem_src, lq_src[Q-1]};
    assign ge    = trial >= {1'b0, len_src};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? Q'(trial - {1'b0, len_src}) : Q'(trial);
        lq_r[i]   <= {lq_src[Q-2:0], ge};
        len_r[i]  <= len_src;
        side_r[i] <= side_src;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_src;
      end
    end
  end

  assign out_valid = vld_r[Q-1];
  assign quot      = lq_r[Q-1];
  assign side_out  = side_r[Q-1];

endmodule

// ===== tb/sv/psd_tb_pkg.sv =====
`timescale 1ns / 1ps
// Query item and answer types shared by the testbench top level.
package psd_tb_pkg;
  import psd_pkg::*;

  typedef struct packed {
    coord_t start_x, start_y, start_z;
    coord_t end_x, end_y, end_z;
    coord_t query_x, query_y, query_z;
  } query_t;

  typedef struct packed {
    dist_t   sq_dist;
    region_t region;
  } answer_t;
endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top level for the point-to-segment squared distance block.
module tb;
  import psd_pkg::*;
  import psd_tb_pkg::*;

  localparam int LATENCY  = 3 + 2 + DIST_BITS + 1;
  localparam int N_RANDOM = 1530;
  localparam logic signed [15:0] CMAX = 16'sh7FFF;
  localparam logic signed [15:0] CMIN = 16'sh8000;

  logic clk;
  logic rst_n;

  psd_in_if  in_ch ();
  psd_out_if out_ch ();

  point_segment_square_distance u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Directed row: item plus an optional typed-in answer.
  typedef struct {
    query_t  q;
    logic    has_ans;
    answer_t ans;
  } row_t;

  answer_t pending_answers[$];
  int      error_count;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Compute the squared distance and region exactly, at wide widths.
  function automatic answer_t segment_distance(query_t q);
    longint  dx, dy, dz, ax, ay, az, bx, by, bz;
    longint  proj, len2, ea, eb;
    logic [127:0] psq;
    logic [127:0] quo;
    answer_t r;
    dx = longint'(q.end_x) - longint'(q.start_x);
    dy = longint'(q.end_y) - longint'(q.start_y);
    dz = longint'(q.end_z) - longint'(q.start_z);
    ax = longint'(q.query_x) - longint'(q.start_x);
    ay = longint'(q.query_y) - longint'(q.start_y);
    az = longint'(q.query_z) - longint'(q.start_z);
    bx = longint'(q.query_x) - longint'(q.end_x);
    by = longint'(q.query_y) - longint'(q.end_y);
    bz = longint'(q.query_z) - longint'(q.end_z);
    proj = ax * dx + ay * dy + az * dz;
    len2 = dx * dx + dy * dy + dz * dz;
    ea = ax * ax + ay * ay + az * az;
    eb = bx * bx + by * by + bz * bz;
    if (proj <= 0) begin
      r.sq_dist = dist_t'(ea);
      r.region = REG_START;
    end else if (proj >= len2) begin
      r.sq_dist = dist_t'(eb);
      r.region = REG_END;
    end else begin
      psq = 128'(proj) * 128'(proj);
      quo = psq / 128'(len2);
      r.sq_dist = dist_t'(ea - longint'(quo[63:0]));
      r.region = REG_MID;
    end
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 64) - 32);
      default: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
    endcase
  endfunction

  // Mostly full-range points; some near-degenerate segments and clustered points.
  function automatic query_t random_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 9);
    q.start_x = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
    q.start_y = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
    q.start_z = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
    if ($urandom_range(0, 15) == 0) begin
      // zero-length segment
      q.end_x = q.start_x;
      q.end_y = q.start_y;
      q.end_z = q.start_z;
    end else begin
      q.end_x = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
      q.end_y = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
      q.end_z = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
    end
    q.query_x = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
    q.query_y = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
    q.query_z = rand_coord(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
    return q;
  endfunction

  // Offer one transaction; hold it until accepted, then drop valid for a
  // cycle unless another item follows without a gap.
  task automatic send_query(query_t q, bit keep_valid);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.start_x <= q.start_x;
    in_ch.start_y <= q.start_y;
    in_ch.start_z <= q.start_z;
    in_ch.end_x   <= q.end_x;
    in_ch.end_y   <= q.end_y;
    in_ch.end_z   <= q.end_z;
    in_ch.query_x <= q.query_x;
    in_ch.query_y <= q.query_y;
    in_ch.query_z <= q.query_z;
    do @(posedge clk); while (!in_ch.ready);
    if (!keep_valid) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic query_t mk(coord_t sx, coord_t sy, coord_t sz, coord_t ex,
                                coord_t ey, coord_t ez, coord_t qx, coord_t qy,
                                coord_t qz);
    query_t q;
    q = '{sx, sy, sz, ex, ey, ez, qx, qy, qz};
    return q;
  endfunction

  // Receiver: random stalls per phase, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // Record the expectation as each input transaction is accepted.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pending_answers.push_back(segment_distance(mk(in_ch.start_x, in_ch.start_y,
        in_ch.start_z, in_ch.end_x, in_ch.end_y, in_ch.end_z, in_ch.query_x,
        in_ch.query_y, in_ch.query_z)));
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: square_distance %0d region %0d",
               out_ch.square_distance, out_ch.region);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.square_distance !== want.sq_dist) begin
          $error("square_distance: expected %0d, actual %0d", want.sq_dist,
                 out_ch.square_distance);
          error_count++;
        end
        if (out_ch.region !== want.region) begin
          $error("region: expected %0d, actual %0d", want.region, out_ch.region);
          error_count++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int   n;
    int   phase;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    {in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x, in_ch.end_y,
     in_ch.end_z, in_ch.query_x, in_ch.query_y, in_ch.query_z} <= '0;

    // Directed rows; answers typed in where obvious, else predicted.
    r.has_ans = 1'b1;
    r.q = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);         r.ans = '{34'd0, REG_START}; rows.push_back(r);
    r.q = mk(0, 0, 0, 0, 0, 0, 3, 4, 0);         r.ans = '{34'd25, REG_START}; rows.push_back(r);
    r.q = mk(0, 0, 0, 10, 0, 0, -2, 0, 0);       r.ans = '{34'd4, REG_START}; rows.push_back(r);
    r.q = mk(0, 0, 0, 10, 0, 0, 13, 4, 0);       r.ans = '{34'd25, REG_END}; rows.push_back(r);
    r.q = mk(0, 0, 0, 10, 0, 0, 10, 0, 0);       r.ans = '{34'd0, REG_END}; rows.push_back(r);
    r.q = mk(0, 0, 0, 10, 0, 0, 5, 7, 0);        r.ans = '{34'd49, REG_MID}; rows.push_back(r);
    r.q = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);         r.ans = '{34'd0, REG_START}; rows.push_back(r);
    r.q = mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    // 3 * 65535 * 65535
    r.ans = '{34'd12884508675, REG_START}; rows.push_back(r);
    r.q = mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    r.ans = '{34'd0, REG_END}; rows.push_back(r);
    r.q = mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    r.ans = '{34'd0, REG_START}; rows.push_back(r);
    r.q = mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN);
    r.ans = '{34'd0, REG_MID}; r.has_ans = 1'b0; rows.push_back(r);
    r.q = mk(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN); rows.push_back(r);
    r.q = mk(-1, -1, -1, 1, 1, 1, 0, 5, -5);     rows.push_back(r);
    r.q = mk(100, -200, 300, -400, 500, -600, 7, 8, 9); rows.push_back(r);
    r.q = mk(CMAX, 0, 0, CMIN, 0, 0, 0, CMAX, CMIN); rows.push_back(r);
    r.q = mk(0, 0, 0, 3, 0, 0, 1, 1, 1);         rows.push_back(r);
    r.q = mk(0, 0, 0, 1, 1, 1, 1, 0, 0);         rows.push_back(r);
    r.q = mk(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
             16'sh0F0F, 16'shF0F0, 16'sh3C3C); rows.push_back(r);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].has_ans && segment_distance(rows[i].q) !== rows[i].ans) begin
        $error("directed row %0d: typed answer disagrees with predictor", i);
        error_count++;
      end
      send_query(rows[i].q, 1'b0);
    end

    // Random phases: free flow, idle sender, stalling receiver, both, and a long receiver hold-off.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        3: begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin
          // Hold the output off long enough to fill the pipe and stall the input.
          send_idle_pct = 0; recv_stall_pct = 0;
          hold_off_cycles <= 3 * LATENCY;
        end
      endcase
      for (n = 0; n < N_RANDOM / 5; n++)
        send_query(random_query(), n != N_RANDOM / 5 - 1 && send_idle_pct == 0);
    end

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0)
      $display("point_segment_square_distance test passed");
    else
      $display("point_segment_square_distance test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("point_segment_square_distance test failed");
    $finish;
  end
endmodule
